// ----- rtl/nplw_pkg.sv -----
// ----------------------------------------------------------------------------
// nplw_pkg
// Shared types and constants for the nonconvex penalty LLA weight block.
// ----------------------------------------------------------------------------
`default_nettype none
package nplw_pkg;
  localparam int unsigned AccW = 48;
  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    MODE_L1   = 2'd0,
    MODE_MCP  = 2'd1,
    MODE_SCAD = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_LAMBDA = 2'd1,
    REG_GAMMA  = 2'd2
  } reg_e;

  typedef struct packed {
    logic [31:0] coefficient;
    logic        last_item;
  } in_t;

  typedef struct packed {
    logic [31:0] weight;
    logic [31:0] pen_value;
    logic [47:0] penalty_total;
    logic [47:0] weighted_total;
    logic [47:0] tangent_total;
    logic        overflow_flag;
    logic        config_invalid;
    logic        last_result;
  } out_t;

  // Per-item work handed from the front to the back.
  typedef struct packed {
    logic [31:0] mag;
    logic [31:0] weight;
    logic [31:0] value;
    logic        sat;
    logic        invalid;
    logic        last;
  } item_t;

  typedef enum logic [2:0] {
    F_IDLE, F_DIV, F_MUL1, F_MUL2, F_PUSH
  } fstate_e;

  typedef enum logic [1:0] {
    B_IDLE, B_MUL, B_ACC, B_OUT
  } bstate_e;
endpackage
`default_nettype wire

// ----- rtl/nplw_front.sv -----
// ----------------------------------------------------------------------------
// nplw_front
// Takes a coefficient, runs the fixed-point divide and value products.
// ----------------------------------------------------------------------------
`default_nettype none
module nplw_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [1:0]       mode_i,
  input  wire logic [31:0]      lambda_i,
  input  wire logic [31:0]      gamma_i,
  input  wire nplw_pkg::in_t    in_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output nplw_pkg::item_t       item_o,
  output logic                  item_valid_o,
  input  wire logic             item_full_i
);
  localparam logic [63:0] One = 64'd65536;

  nplw_pkg::fstate_e st_q, st_d;
  logic [31:0] mag_q, lam_q;
  logic [63:0] gam_q, den_q;
  logic [1:0]  mode_q;
  logic        inv_q, last_q, big_q;
  // divider
  logic [64:0] rem_q;
  logic [63:0] num_q, quo_q;
  logic [6:0]  cnt_q;
  logic [31:0] off_q;
  // products
  logic [63:0] pa_q, pb_q, pc_q, pd_q;
  logic [31:0] w_q, v_q;
  logic        usek_q;
  logic [1:0]  kind_q;

  logic [31:0] c, a;
  logic [63:0] gx;
  logic        inv;
  logic [1:0]  md;
  assign c  = in_data_i.coefficient;
  assign a  = c[31] ? (~c + 32'd1) : c;
  assign gx = {32'd0, gamma_i};
  assign inv = (mode_i == nplw_pkg::MODE_RSVD) ||
               (mode_i == nplw_pkg::MODE_MCP && gx <= One) ||
               (mode_i == nplw_pkg::MODE_SCAD && gx <= (One << 1));
  assign md = inv ? nplw_pkg::MODE_L1 : mode_i;

  logic [64:0] rsh;
  assign rsh = {rem_q[63:0], num_q[63]};

  // Operands never exceed 33 bits; the wide intermediate of the flat-region
  // value is split into high and low halves for the second stage.
  logic [32:0]  x1, y1, x2, y2;
  logic [65:0]  m1, m2;
  logic [49:0]  p1;
  logic [48:0]  p2;
  assign x1 = pa_q[32:0];
  assign y1 = pb_q[32:0];
  assign x2 = pc_q[32:0];
  assign y2 = pd_q[32:0];
  assign m1 = {33'd0, x1} * {33'd0, y1};
  assign m2 = {33'd0, x2} * {33'd0, y2};
  // p1 is >>16, p2 is >>17
  assign p1 = m1[65:16];
  assign p2 = m2[65:17];

  always_comb begin
    st_d = st_q;
    in_stall_o = (st_q != nplw_pkg::F_IDLE);
    item_valid_o = (st_q == nplw_pkg::F_PUSH) && !item_full_i;
    unique case (st_q)
      nplw_pkg::F_IDLE: if (in_valid_i) st_d = (md == nplw_pkg::MODE_L1 ||
                          lambda_i == 32'd0) ? nplw_pkg::F_MUL1 : nplw_pkg::F_DIV;
      nplw_pkg::F_DIV:  if (cnt_q == 7'd0 || big_q) st_d = nplw_pkg::F_MUL1;
      nplw_pkg::F_MUL1: st_d = nplw_pkg::F_MUL2;
      nplw_pkg::F_MUL2: st_d = nplw_pkg::F_PUSH;
      nplw_pkg::F_PUSH: if (!item_full_i) st_d = nplw_pkg::F_IDLE;
      default: st_d = nplw_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= nplw_pkg::F_IDLE;
    else st_q <= st_d;
  end

  logic [63:0] q_fin;
  logic [63:0] lam64, a64, l2;
  assign q_fin = big_q ? 64'hFFFF_FFFF_FFFF_FFFF : quo_q;
  assign lam64 = {32'd0, lam_q};
  assign a64   = {32'd0, mag_q};
  assign l2    = lam64 << 1;

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      nplw_pkg::F_IDLE: if (in_valid_i) begin
        mag_q <= a; lam_q <= lambda_i; mode_q <= md; inv_q <= inv;
        last_q <= in_data_i.last_item;
        gam_q <= gx;
        // SCAD outer region divides the offset by gamma-1
        if (md == nplw_pkg::MODE_SCAD) begin
          den_q <= gx - One;
          off_q <= a - lambda_i;
          num_q <= {32'd0, a - lambda_i} << 16;
          rem_q <= {49'd0, 16'(({32'd0, a - lambda_i}) >> 48)};
          big_q <= 1'b0;
        end else begin
          den_q <= gx; off_q <= a;
          num_q <= {32'd0, a} << 16;
          rem_q <= 65'd0;
          big_q <= 1'b0;
        end
        cnt_q <= 7'd64;
        quo_q <= 64'd0;
      end
      nplw_pkg::F_DIV: if (cnt_q != 7'd0) begin
        cnt_q <= cnt_q - 7'd1;
        num_q <= num_q << 1;
        if (rsh[64] || rsh[63:0] >= den_q) begin
          rem_q <= {1'b0, rsh[63:0] - den_q};
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= {1'b0, rsh[63:0]};
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
      nplw_pkg::F_MUL1: begin
        // choose weight and first-stage operands
        usek_q <= 1'b0;
        kind_q <= 2'd0;
        if (mode_q == nplw_pkg::MODE_L1 || lam_q == 32'd0) begin
          w_q <= (mode_q == nplw_pkg::MODE_L1) ? lam_q : 32'd0;
          pa_q <= lam64; pb_q <= (mode_q == nplw_pkg::MODE_L1) ? a64 : 64'd0;
          pc_q <= 64'd0; pd_q <= 64'd0;
        end else if (mode_q == nplw_pkg::MODE_MCP) begin
          if (q_fin < lam64) begin
            w_q <= lam_q - q_fin[31:0];
            pa_q <= 64'd0; pb_q <= 64'd0;
            pc_q <= a64; pd_q <= l2 - q_fin;
          end else begin
            w_q <= 32'd0; kind_q <= 2'd1;
            pa_q <= gam_q; pb_q <= lam64; pc_q <= 64'd0; pd_q <= 64'd0;
          end
        end else if (mag_q <= lam_q) begin
          w_q <= lam_q;
          pa_q <= lam64; pb_q <= a64; pc_q <= 64'd0; pd_q <= 64'd0;
        end else if (q_fin < lam64) begin
          w_q <= lam_q - q_fin[31:0];
          pa_q <= lam64; pb_q <= lam64;
          pc_q <= {32'd0, off_q}; pd_q <= l2 - q_fin;
        end else begin
          w_q <= 32'd0; kind_q <= 2'd1;
          pa_q <= gam_q + One; pb_q <= lam64; pc_q <= 64'd0; pd_q <= 64'd0;
        end
      end
      nplw_pkg::F_MUL2: begin
        if (kind_q == 2'd1) begin
          // second stage: (p*L)>>17 as high and low partial products
          pa_q <= {46'd0, p1[49:32]}; pb_q <= lam64;
          pc_q <= {32'd0, p1[31:0]}; pd_q <= lam64;
          usek_q <= 1'b1;
        end else begin
          usek_q <= 1'b0;
          pa_q <= {14'd0, p1}; pb_q <= {15'd0, p2};
        end
      end
      nplw_pkg::F_PUSH: ;
      default: ;
    endcase
  end

  // final value assembly in the push state
  logic [98:0] kp;
  logic [64:0] vs;
  logic [31:0] vv;
  logic        vsat;
  assign kp = {1'b0, m1, 32'd0} + {33'd0, m2};
  assign vs = {1'b0, pa_q} + {1'b0, pb_q};
  always_comb begin
    if (usek_q) begin
      vv = kp[48:17];
      vsat = |kp[98:49];
    end else begin
      vv = vs[31:0];
      vsat = |vs[64:32];
    end
  end

  always_comb begin
    item_o.mag     = mag_q;
    item_o.weight  = w_q;
    item_o.value   = vsat ? 32'hFFFF_FFFF : vv;
    item_o.sat     = vsat;
    item_o.invalid = inv_q;
    item_o.last    = last_q;
  end
endmodule
`default_nettype wire

// ----- rtl/nplw_queue.sv -----
// ----------------------------------------------------------------------------
// nplw_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module nplw_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nplw_pkg::item_t wr_data_i,
  input  wire logic            wr_i,
  output logic                 full_o,
  output nplw_pkg::item_t      rd_data_o,
  output logic                 empty_o,
  input  wire logic            rd_i
);
  nplw_pkg::item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rd_data_o = mem_q[rp_q];
  always_ff @(posedge clk_i) if (wr_i) mem_q[wp_q] <= wr_data_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end
endmodule
`default_nettype wire

// ----- rtl/nplw_back.sv -----
// ----------------------------------------------------------------------------
// nplw_back
// Weighted term, saturating sums and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module nplw_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire nplw_pkg::item_t item_i,
  input  wire logic            empty_i,
  output logic                 rd_o,
  output nplw_pkg::out_t       out_data_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i
);
  localparam logic [47:0] AccMax = {48{1'b1}};
  nplw_pkg::bstate_e st_q, st_d;
  nplw_pkg::item_t it_q;
  logic [63:0] wa_q;
  logic [47:0] pacc_q, wacc_q, tacc_q;
  logic        seen_q;
  nplw_pkg::out_t res_q;

  always_comb begin
    st_d = st_q; rd_o = 1'b0;
    unique case (st_q)
      nplw_pkg::B_IDLE: if (!empty_i) begin rd_o = 1'b1; st_d = nplw_pkg::B_MUL; end
      nplw_pkg::B_MUL: st_d = nplw_pkg::B_ACC;
      nplw_pkg::B_ACC: st_d = nplw_pkg::B_OUT;
      nplw_pkg::B_OUT: if (!out_stall_i) st_d = nplw_pkg::B_IDLE;
      default: st_d = nplw_pkg::B_IDLE;
    endcase
  end
  assign out_valid_o = st_q == nplw_pkg::B_OUT;
  assign out_data_o = res_q;

  logic [63:0] wm;
  assign wm = {32'd0, it_q.weight} * {32'd0, it_q.mag};

  logic [48:0] ps, ws;
  logic signed [49:0] ts;
  logic [47:0] wa48, pn, wn, tn;
  logic s;
  always_comb begin
    s = it_q.sat | (|wa_q[63:48]);
    wa48 = (|wa_q[63:48]) ? AccMax : wa_q[47:0];
    ps = {1'b0, pacc_q} + {17'd0, it_q.value};
    ws = {1'b0, wacc_q} + {1'b0, wa48};
    ts = $signed({{2{tacc_q[47]}}, tacc_q}) + $signed({18'd0, it_q.value})
         - $signed({2'b00, wa48});
    pn = ps[48] ? AccMax : ps[47:0];
    wn = ws[48] ? AccMax : ws[47:0];
    tn = ts[49:47] == 3'b000 || ts[49:47] == 3'b111 ? ts[47:0] :
         (ts[49] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
    s = s | ps[48] | ws[48] | !(ts[49:47] == 3'b000 || ts[49:47] == 3'b111);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= nplw_pkg::B_IDLE;
      pacc_q <= '0; wacc_q <= '0; tacc_q <= '0; seen_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == nplw_pkg::B_ACC) begin
        if (it_q.last) begin
          pacc_q <= '0; wacc_q <= '0; tacc_q <= '0; seen_q <= 1'b0;
        end else begin
          pacc_q <= pn; wacc_q <= wn; tacc_q <= tn; seen_q <= seen_q | s;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_o) it_q <= item_i;
    if (st_q == nplw_pkg::B_MUL) wa_q <= wm >> 16;
    if (st_q == nplw_pkg::B_ACC) begin
      res_q.weight <= it_q.weight;
      res_q.pen_value <= it_q.value;
      res_q.penalty_total <= pn;
      res_q.weighted_total <= wn;
      res_q.tangent_total <= tn;
      res_q.overflow_flag <= seen_q | s;
      res_q.config_invalid <= it_q.invalid;
      res_q.last_result <= it_q.last;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/nonconvex_penalty_lla_weights_core.sv -----
// ----------------------------------------------------------------------------
// nonconvex_penalty_lla_weights_core
// LLA weights and penalty values for L1, MCP and SCAD, with running sums.
// ----------------------------------------------------------------------------
// Usage: write penalty_mode, lambda and gamma on the cfg port while idle.
// Coefficients enter on in_valid_i/in_stall_o; each transfer gives one
// result on out_valid_o/out_stall_i carrying weight, value and sums.
// The front runs a 64-step radix-2 divider (one quotient bit a cycle) and
// two product stages; for L1 or zero lambda the divider is skipped.
// The back registers the product, then the sums and the result together.
// A two-entry queue parts the two, so the front takes the next item while
// a result waits on a stalled receiver. The front takes a new coefficient
// only after it has pushed the last one into the queue.
// Reset clears sums, flag and queue and sets the config registers to their reset values.
// A stalled result holds; the queue fills and then the input stalls.
// Sums and the overflow flag clear after a result marked last.
// ----------------------------------------------------------------------------
`default_nettype none
module nonconvex_penalty_lla_weights_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic [1:0]     cfg_index_i,
  input  wire logic [31:0]    cfg_data_i,
  input  wire nplw_pkg::in_t  in_data_i,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output nplw_pkg::out_t      out_data_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i
);
  logic [1:0]  mode_q;
  logic [31:0] lambda_q, gamma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= nplw_pkg::MODE_L1; lambda_q <= '0; gamma_q <= 32'd196608;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nplw_pkg::REG_MODE:   mode_q <= cfg_data_i[1:0];
        nplw_pkg::REG_LAMBDA: lambda_q <= cfg_data_i;
        nplw_pkg::REG_GAMMA:  gamma_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  nplw_pkg::item_t f_item, q_item;
  logic f_valid, q_full, q_empty, q_rd;

  nplw_front u_front (
    .clk_i, .rst_ni, .mode_i(mode_q), .lambda_i(lambda_q), .gamma_i(gamma_q),
    .in_data_i, .in_valid_i, .in_stall_o,
    .item_o(f_item), .item_valid_o(f_valid), .item_full_i(q_full)
  );

  nplw_queue u_queue (
    .clk_i, .rst_ni, .wr_data_i(f_item), .wr_i(f_valid), .full_o(q_full),
    .rd_data_o(q_item), .empty_o(q_empty), .rd_i(q_rd)
  );

  nplw_back u_back (
    .clk_i, .rst_ni, .item_i(q_item), .empty_i(q_empty), .rd_o(q_rd),
    .out_data_o, .out_valid_o, .out_stall_i
  );
endmodule
`default_nettype wire
